@@ rtl/stdm_pkg.sv @@
// Shared types and constants of the toggle and duty meter.
package stdm_pkg;

	// Fixed result field widths.
	localparam int OUT_COUNT_W = 32;
	localparam int OUT_TIME_W  = 40;
	localparam int DUTY_W      = 16;
	localparam int ACTIVITY_W  = 24;

	// Activity is count * 2^ACT_SHIFT / periods; ACT_HEAD quotient bits sit above the shift.
	localparam int ACT_SHIFT   = 15;
	localparam int ACT_HEAD    = ACTIVITY_W - ACT_SHIFT;

	localparam int CPR_W       = 32;
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_IDX_W   = 2;

	// Divider sequencing: activity needs one step per quotient bit, duty runs in the last ones.
	localparam int ACT_STEPS   = ACTIVITY_W;
	localparam int DUTY_STEPS  = DUTY_W;
	localparam int STEP_CNT_W  = $clog2(ACT_STEPS);

	localparam logic [OUT_COUNT_W-1:0] OUT_COUNT_MAX = '1;
	localparam logic [OUT_TIME_W-1:0]  OUT_TIME_SAT  = '1;

	typedef enum logic [1:0] {
		VAL_ZERO = 2'd0,
		VAL_ONE  = 2'd1,
		VAL_X    = 2'd2,
		VAL_Z    = 2'd3
	} sig_val_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_END_TIME      = 2'd0,
		CFG_CLOCK_PERIODS = 2'd1
	} cfg_reg_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic take;       // sample word accepted this cycle
		logic close;      // close high time up to end time
		logic load;       // load dividers, clear record state
		logic step;       // one activity division step
		logic duty_step;  // one duty division step
		logic publish;    // move finished results to output registers
	} ctrl_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic last_in;    // offered sample word closes its record
	} dp_status_t;

endpackage

@@ rtl/stdm_if.sv @@
// Channel interfaces: sample words in, result words out, configuration writes.
interface stdm_in_if #(parameter int TIME_BITS = 40) ();
	logic                 valid;
	logic                 ready;
	logic [TIME_BITS-1:0] sample_time;
	logic [1:0]           sample_value;
	logic                 last_sample;

	modport source (output valid, sample_time, sample_value, last_sample, input ready);
	modport sink   (input valid, sample_time, sample_value, last_sample, output ready);
endinterface

interface stdm_out_if ();
	logic        valid;
	logic        ready;
	logic [31:0] half_transitions;
	logic [39:0] time_high;
	logic [15:0] duty_fraction;
	logic [23:0] activity_rate;

	modport source (output valid, half_transitions, time_high, duty_fraction, activity_rate,
		input ready);
	modport sink   (input valid, half_transitions, time_high, duty_fraction, activity_rate,
		output ready);
endinterface

interface stdm_cfg_if ();
	logic        valid;
	logic        ready;
	logic [1:0]  reg_index;
	logic [63:0] data;

	modport source (output valid, reg_index, data, input ready);
	modport sink   (input valid, reg_index, data, output ready);
endinterface

@@ rtl/signal_toggle_and_duty_meter.sv @@
// Top level of the signal toggle and duty meter.
// Sample words that do not close their record are taken back to back while accumulating.
// A closing word holds off the input while the meter closes the high interval, loads the
// dividers, runs 24 bit-serial division steps and publishes the result word; publishing
// waits while the previous result word has not been taken.
// Reset (arst_n low, asynchronous) clears the record state and sets both registers to 1.
module signal_toggle_and_duty_meter
	import stdm_pkg::*;
#(
	parameter int TIME_BITS  = 40,
	parameter int COUNT_BITS = 32
) (
	input logic        clk,
	input logic        arst_n,
	stdm_in_if.sink    smp,
	stdm_out_if.source res,
	stdm_cfg_if.sink   cfg
);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	// Config writes are always taken; the user must issue them only while idle (not enforced).
	assign cfg.ready = 1'b1;

	// Controller: owns the sample and result handshakes and the division step count.
	stdm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (smp.valid),
		.in_ready  (smp.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Datapath: accumulators, shared interval adder, both dividers, result word.
	stdm_dp #(
		.TIME_BITS  (TIME_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.sample_time      (smp.sample_time),
		.sample_value     (smp.sample_value),
		.last_sample      (smp.last_sample),
		.cfg_we           (cfg.valid),
		.cfg_index        (cfg.reg_index),
		.cfg_data         (cfg.data),
		.half_transitions (res.half_transitions),
		.time_high        (res.time_high),
		.duty_fraction    (res.duty_fraction),
		.activity_rate    (res.activity_rate)
	);

endmodule

@@ rtl/stdm_ctrl.sv @@
// Sequencer of the toggle and duty meter: accumulate, close, load, divide, publish.
module stdm_ctrl
	import stdm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_ACC,
		ST_CLOSE,
		ST_LOAD,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t                state_q;
	logic [STEP_CNT_W-1:0] cnt_q;
	logic                  out_valid_q;
	logic                  can_publish;

	assign in_ready    = (state_q == ST_ACC);
	assign out_valid   = out_valid_q;
	assign can_publish = !out_valid_q || out_ready;

	always_comb begin
		cmd           = '0;
		cmd.take      = in_ready && in_valid;
		cmd.close     = (state_q == ST_CLOSE);
		cmd.load      = (state_q == ST_LOAD);
		cmd.step      = (state_q == ST_DIV);
		cmd.duty_step = (state_q == ST_DIV) && (cnt_q < STEP_CNT_W'(DUTY_STEPS));
		cmd.publish   = (state_q == ST_DONE) && can_publish;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_ACC;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.publish)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_ACC: begin
					if (in_valid && status.last_in)
						state_q <= ST_CLOSE;
				end
				ST_CLOSE: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					cnt_q   <= STEP_CNT_W'(ACT_STEPS - 1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == '0)
						state_q <= ST_DONE;
					else
						cnt_q <= cnt_q - 1'b1;
				end
				ST_DONE: begin
					if (can_publish)
						state_q <= ST_ACC;
				end
				default: begin
					state_q <= ST_ACC;
				end
			endcase
		end
	end

endmodule

@@ rtl/stdm_dp.sv @@
// Datapath: record accumulators, interval adder, bit-serial dividers, result registers.
module stdm_dp
	import stdm_pkg::*;
#(
	parameter int TIME_BITS  = 40,
	parameter int COUNT_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ctrl_cmd_t              cmd,
	output dp_status_t             status,
	input  logic [TIME_BITS-1:0]   sample_time,
	input  logic [1:0]             sample_value,
	input  logic                   last_sample,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output logic [OUT_COUNT_W-1:0] half_transitions,
	output logic [OUT_TIME_W-1:0]  time_high,
	output logic [DUTY_W-1:0]      duty_fraction,
	output logic [ACTIVITY_W-1:0]  activity_rate
);

	localparam int CW = (COUNT_BITS > OUT_COUNT_W) ? COUNT_BITS : OUT_COUNT_W;
	localparam int TW = (TIME_BITS > OUT_TIME_W) ? TIME_BITS : OUT_TIME_W;

	// config
	logic [TIME_BITS-1:0]  end_time_q;
	logic [CPR_W-1:0]      cpr_q;

	// record state
	logic                  seen_q;
	logic [1:0]            prev_val_q;
	logic [TIME_BITS-1:0]  prev_time_q;
	logic [TIME_BITS-1:0]  acc_q;
	logic [COUNT_BITS-1:0] hcnt_q;

	// divider and result registers
	logic [OUT_COUNT_W-1:0] hc_res_q;
	logic [OUT_TIME_W-1:0]  th_res_q;
	logic                   act_sat_q;
	logic                   duty_sat_q;
	logic [CPR_W-1:0]       act_rem_q;
	logic [ACTIVITY_W-1:0]  act_num_q;
	logic [ACTIVITY_W-1:0]  act_quo_q;
	logic [TIME_BITS-1:0]   duty_rem_q;
	logic [DUTY_W-1:0]      duty_quo_q;
	logic [OUT_COUNT_W-1:0] half_transitions_q;
	logic [OUT_TIME_W-1:0]  time_high_q;
	logic [DUTY_W-1:0]      duty_fraction_q;
	logic [ACTIVITY_W-1:0]  activity_rate_q;

	// interval adder, shared by sample words and the closing interval
	logic [TIME_BITS-1:0]  endp;
	logic [TIME_BITS-1:0]  gap;
	logic                  add_en;
	logic [TIME_BITS:0]    acc_sum;
	logic [TIME_BITS-1:0]  acc_next;

	// transition counter
	logic                  val_xz;
	logic [1:0]            inc;
	logic [COUNT_BITS:0]   hcnt_sum;
	logic [COUNT_BITS-1:0] hcnt_next;

	// clamps
	logic [CW-1:0]          hc_wide;
	logic [OUT_COUNT_W-1:0] hc_clamp;
	logic [TW-1:0]          th_wide;
	logic [OUT_TIME_W-1:0]  th_clamp;

	// divider steps
	logic [CPR_W:0]         act_r2;
	logic                   act_bit;
	logic [TIME_BITS:0]     duty_r2;
	logic                   duty_bit;

	assign status.last_in = last_sample;

	assign endp     = cmd.close ? end_time_q : sample_time;
	assign gap      = endp - prev_time_q;
	assign add_en   = (prev_val_q == VAL_ONE) && (endp > prev_time_q);
	assign acc_sum  = {1'b0, acc_q} + {1'b0, gap};
	assign acc_next = acc_sum[TIME_BITS] ? '1 : acc_sum[TIME_BITS-1:0];

	assign val_xz    = (sample_value == VAL_X) || (sample_value == VAL_Z) ||
		(prev_val_q == VAL_X) || (prev_val_q == VAL_Z);
	assign inc       = val_xz ? 2'd1 : 2'd2;
	assign hcnt_sum  = {1'b0, hcnt_q} + (COUNT_BITS + 1)'(inc);
	assign hcnt_next = hcnt_sum[COUNT_BITS] ? '1 : hcnt_sum[COUNT_BITS-1:0];

	assign hc_wide  = CW'(hcnt_q);
	assign hc_clamp = (hc_wide > CW'(OUT_COUNT_MAX)) ? OUT_COUNT_MAX : hc_wide[OUT_COUNT_W-1:0];
	assign th_wide  = TW'(acc_q);
	assign th_clamp = (th_wide > TW'(OUT_TIME_SAT)) ? OUT_TIME_SAT : th_wide[OUT_TIME_W-1:0];

	// restoring division steps
	assign act_r2   = {act_rem_q, act_num_q[ACTIVITY_W-1]};
	assign act_bit  = (act_r2 >= {1'b0, cpr_q});
	assign duty_r2  = {duty_rem_q, 1'b0};
	assign duty_bit = (duty_r2 >= {1'b0, end_time_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_time_q  <= TIME_BITS'(1);
			cpr_q       <= CPR_W'(1);
			seen_q      <= 1'b0;
			prev_val_q  <= VAL_ZERO;
			prev_time_q <= '0;
			acc_q       <= '0;
			hcnt_q      <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_END_TIME:      end_time_q <= cfg_data[TIME_BITS-1:0];
					CFG_CLOCK_PERIODS: cpr_q      <= cfg_data[CPR_W-1:0];
					default: ;
				endcase
			end
			if (cmd.take) begin
				if (seen_q) begin
					if (add_en)
						acc_q <= acc_next;
					if (sample_value != prev_val_q)
						hcnt_q <= hcnt_next;
				end
				seen_q      <= 1'b1;
				prev_val_q  <= sample_value;
				prev_time_q <= sample_time;
			end
			if (cmd.close && add_en)
				acc_q <= acc_next;
			if (cmd.load) begin
				seen_q      <= 1'b0;
				prev_val_q  <= VAL_ZERO;
				prev_time_q <= '0;
				acc_q       <= '0;
				hcnt_q      <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			hc_res_q   <= hc_clamp;
			th_res_q   <= th_clamp;
			// quotient would not fit in 24 bits (also covers zero periods)
			act_sat_q  <= ({{ACT_HEAD{1'b0}}, hc_clamp} >= {cpr_q, {ACT_HEAD{1'b0}}});
			act_rem_q  <= CPR_W'(hc_clamp >> ACT_HEAD);
			act_num_q  <= {hc_clamp[ACT_HEAD-1:0], {ACT_SHIFT{1'b0}}};
			act_quo_q  <= '0;
			duty_sat_q <= (end_time_q == '0) || (acc_q >= end_time_q);
			duty_rem_q <= acc_q;
			duty_quo_q <= '0;
		end
		if (cmd.step) begin
			act_rem_q <= act_bit ? CPR_W'(act_r2 - {1'b0, cpr_q}) : act_r2[CPR_W-1:0];
			act_num_q <= {act_num_q[ACTIVITY_W-2:0], 1'b0};
			act_quo_q <= {act_quo_q[ACTIVITY_W-2:0], act_bit};
		end
		if (cmd.duty_step) begin
			duty_rem_q <= duty_bit ? TIME_BITS'(duty_r2 - {1'b0, end_time_q})
				: duty_r2[TIME_BITS-1:0];
			duty_quo_q <= {duty_quo_q[DUTY_W-2:0], duty_bit};
		end
		if (cmd.publish) begin
			half_transitions_q <= hc_res_q;
			time_high_q        <= th_res_q;
			duty_fraction_q    <= duty_sat_q ? '1 : duty_quo_q;
			activity_rate_q    <= act_sat_q ? '1 : act_quo_q;
		end
	end

	assign half_transitions = half_transitions_q;
	assign time_high        = time_high_q;
	assign duty_fraction    = duty_fraction_q;
	assign activity_rate    = activity_rate_q;

endmodule

@@ verif/signal_toggle_and_duty_meter_tb.sv @@
// Testbench for the toggle and duty meter: random sample records checked against a predictor.
`timescale 1ns / 1ps

module signal_toggle_and_duty_meter_tb
	import stdm_pkg::*;
();

	localparam int TB_TIME_W    = 40;
	localparam int TB_COUNT_W   = 32;
	localparam logic [TB_TIME_W-1:0]  TB_TIME_TOP = '1;
	localparam logic [TB_COUNT_W-1:0] COUNT_MAX   = '1;
	localparam logic [CPR_W-1:0]      CPR_MAX     = '1;
	// time for a closing word to finish, plus margin
	localparam int SETTLE_CYCLES = 40;
	localparam int LONG_HOLD     = 400;
	localparam int CYCLE_LIMIT   = 500000;
	localparam int MAX_SHOWN     = 10;

	// One result word as the meter reports it.
	typedef struct {
		logic [OUT_COUNT_W-1:0] halves;
		logic [OUT_TIME_W-1:0]  hi_span;
		logic [DUTY_W-1:0]      duty;
		logic [ACTIVITY_W-1:0]  activity;
	} meter_reading_t;

	// Tracks the meter's record state and queues the readings it must produce.
	class meter_scoreboard;
		logic [TB_TIME_W-1:0]  end_time_r;
		logic [CPR_W-1:0]      periods_r;
		bit                    seeded;
		sig_val_t              prev_val;
		logic [TB_TIME_W-1:0]  prev_t;
		logic [TB_TIME_W-1:0]  high_acc;
		logic [TB_COUNT_W-1:0] halves;
		meter_reading_t        readings_due[$];
		int unsigned           errors;

		function new();
			end_time_r = 1;
			periods_r  = 1;
			errors     = 0;
			clear_record();
		endfunction

		function void clear_record();
			seeded   = 1'b0;
			prev_val = VAL_ZERO;
			prev_t   = '0;
			high_acc = '0;
			halves   = '0;
		endfunction

		// High time from prev_t up to t when the signal sat at one; saturates.
		function void add_high(logic [TB_TIME_W-1:0] t);
			logic [63:0] sum;
			if (prev_val == VAL_ONE && t > prev_t) begin
				sum = 64'(high_acc) + 64'(t - prev_t);
				high_acc = (sum > 64'(TB_TIME_TOP)) ? TB_TIME_TOP : sum[TB_TIME_W-1:0];
			end
		endfunction

		function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] d);
			case (idx)
				CFG_END_TIME: begin
					end_time_r = d[TB_TIME_W-1:0];
				end
				CFG_CLOCK_PERIODS: begin
					periods_r = d[CPR_W-1:0];
				end
				default: begin
				end
			endcase
		endfunction

		function void take_sample(logic [TB_TIME_W-1:0] t, sig_val_t v, logic last);
			meter_reading_t r;
			logic [63:0]    sum;
			logic [63:0]    quo;
			if (!seeded) begin
				seeded = 1'b1;
			end else begin
				add_high(t);
				if (v != prev_val) begin
					// X or Z on either side counts half a transition
					sum = 64'(halves) + ((v >= VAL_X || prev_val >= VAL_X) ? 64'd1 : 64'd2);
					halves = (sum > 64'(COUNT_MAX)) ? COUNT_MAX : sum[TB_COUNT_W-1:0];
				end
			end
			prev_t   = t;
			prev_val = v;
			if (!last)
				return;
			add_high(end_time_r);
			r.halves  = halves;
			r.hi_span = high_acc;
			if (end_time_r == '0 || high_acc >= end_time_r) begin
				r.duty = '1;
			end else begin
				quo    = {8'd0, high_acc, 16'd0} / 64'(end_time_r);
				r.duty = quo[DUTY_W-1:0];
			end
			if (periods_r == '0) begin
				r.activity = '1;
			end else begin
				quo        = {17'd0, halves, 15'd0} / 64'(periods_r);
				r.activity = (quo > 64'hFF_FFFF) ? '1 : quo[ACTIVITY_W-1:0];
			end
			readings_due.push_back(r);
			clear_record();
		endfunction

		function void note_error(string msg);
			errors++;
			if (errors <= MAX_SHOWN)
				$display("%s", msg);
		endfunction

		function void check_result(meter_reading_t got);
			meter_reading_t want;
			if (readings_due.size() == 0) begin
				note_error($sformatf("unexpected result: halves %0d high %0d duty %0d act %0d",
					got.halves, got.hi_span, got.duty, got.activity));
				return;
			end
			want = readings_due.pop_front();
			if (got.halves !== want.halves || got.hi_span !== want.hi_span ||
				got.duty !== want.duty || got.activity !== want.activity)
				note_error($sformatf({"mismatch: expected halves %0d high %0d duty %0d act %0d,",
					" actual halves %0d high %0d duty %0d act %0d"},
					want.halves, want.hi_span, want.duty, want.activity,
					got.halves, got.hi_span, got.duty, got.activity));
		endfunction

		function int unsigned pending();
			return readings_due.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	stdm_in_if #(.TIME_BITS(TB_TIME_W)) smp_if ();
	stdm_out_if res_if ();
	stdm_cfg_if cfg_if ();

	signal_toggle_and_duty_meter #(
		.TIME_BITS  (TB_TIME_W),
		.COUNT_BITS (TB_COUNT_W)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.smp    (smp_if),
		.res    (res_if),
		.cfg    (cfg_if)
	);

	meter_scoreboard sb = new();

	// Idle odds in percent, set per phase by the stimulus process.
	int unsigned tx_idle_pct;
	int unsigned rx_idle_pct;
	// Asks the result side for one long hold-off.
	bit          long_hold_req;
	int unsigned cycle_count;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	initial begin : watchdog
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// Result side: checks every accepted word, toggles ready at random and serves
	// one long hold-off that backs the meter up into its input.
	initial begin : result_side
		int unsigned    hold_left;
		bit             hold_served;
		meter_reading_t got;
		hold_left   = 0;
		hold_served = 1'b0;
		res_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			// values seen here are the ones before this edge
			if (res_if.valid && res_if.ready) begin
				got.halves   = res_if.half_transitions;
				got.hi_span  = res_if.time_high;
				got.duty     = res_if.duty_fraction;
				got.activity = res_if.activity_rate;
				sb.check_result(got);
			end
			if (long_hold_req && !hold_served) begin
				hold_left   = LONG_HOLD;
				hold_served = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	function automatic logic [63:0] rand_upto(logic [63:0] bound);
		return {$urandom, $urandom} % (bound + 64'd1);
	endfunction

	// Offers one sample word, with random idle cycles ahead of it, and waits for it to go in.
	task automatic send_sample(input logic [TB_TIME_W-1:0] t, input sig_val_t v,
		input logic last);
		while ($urandom_range(99) < tx_idle_pct) begin
			smp_if.valid <= 1'b0;
			@(posedge clk);
		end
		smp_if.valid        <= 1'b1;
		smp_if.sample_time  <= t;
		smp_if.sample_value <= v;
		smp_if.last_sample  <= last;
		do
			@(posedge clk);
		while (!smp_if.ready);
		sb.take_sample(t, v, last);
	endtask

	// Drops valid; called in the step of the last acceptance, never right before a raise.
	task automatic stop_samples();
		smp_if.valid <= 1'b0;
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] d);
		cfg_if.valid     <= 1'b1;
		cfg_if.reg_index <= idx;
		cfg_if.data      <= d;
		do
			@(posedge clk);
		while (!cfg_if.ready);
		sb.set_reg(idx, d);
		cfg_if.valid <= 1'b0;
	endtask

	// Waits for every due reading; with settle, also lets a closing word finish.
	task automatic drain(input bit settle);
		while (sb.pending() != 0)
			@(posedge clk);
		if (settle)
			repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Random records: mostly short, nondecreasing times spread over the end time,
	// with the odd backwards step and the odd sample anywhere, often past the end.
	task automatic send_records(input int unsigned n_items);
		int unsigned sent;
		int unsigned len;
		logic [63:0] t;
		logic [63:0] step;
		sig_val_t    v;
		sent = 0;
		while (sent < n_items) begin
			len  = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
			step = 64'(sb.end_time_r) / 64'(len + 1);
			t    = rand_upto(64'(sb.end_time_r) / 4);
			for (int k = 1; k <= len; k++) begin
				case ($urandom_range(19))
					0: t = rand_upto(t);
					1: t = rand_upto(64'(TB_TIME_TOP));
					default: t = t + rand_upto(step * 2);
				endcase
				if (t > 64'(TB_TIME_TOP))
					t = 64'(TB_TIME_TOP);
				// mostly clean levels, some X and Z
				v = ($urandom_range(9) < 7) ? sig_val_t'($urandom_range(1)) :
					sig_val_t'($urandom_range(2, 3));
				send_sample(t[TB_TIME_W-1:0], v, k == len);
			end
			sent += len;
		end
	endtask

	initial begin : stimulus
		logic [63:0] end_val;
		logic [63:0] cpr_val;
		smp_if.valid        <= 1'b0;
		smp_if.sample_time  <= '0;
		smp_if.sample_value <= VAL_ZERO;
		smp_if.last_sample  <= 1'b0;
		cfg_if.valid        <= 1'b0;
		cfg_if.reg_index    <= CFG_END_TIME;
		cfg_if.data         <= '0;
		arst_n              <= 1'b0;
		tx_idle_pct   = 31;
		rx_idle_pct   = 65;
		long_hold_req = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (SETTLE_CYCLES) @(posedge clk);

		// Directed records at end time 1000 and the periods register set to 10.
		write_reg(CFG_END_TIME, 64'd1000);
		write_reg(CFG_CLOCK_PERIODS, 64'd10);
		// single-sample record: seeds and closes at once
		send_sample(40'd5, VAL_ONE, 1'b1);
		// clean and X/Z value changes, time going backwards, samples past end time
		send_sample(40'd0, VAL_ZERO, 1'b0);
		send_sample(40'd100, VAL_ONE, 1'b0);
		send_sample(40'd300, VAL_X, 1'b0);
		send_sample(40'd350, VAL_ONE, 1'b0);
		send_sample(40'd400, VAL_Z, 1'b0);
		send_sample(40'd450, VAL_ZERO, 1'b0);
		send_sample(40'd500, VAL_ONE, 1'b0);
		send_sample(40'd200, VAL_ZERO, 1'b0);
		send_sample(40'd2000, VAL_ONE, 1'b0);
		send_sample(40'd2500, VAL_ONE, 1'b1);
		// high time wraps past the time range twice: accumulator saturates
		send_sample(40'd0, VAL_ONE, 1'b0);
		send_sample(TB_TIME_TOP, VAL_ONE, 1'b0);
		send_sample(40'd0, VAL_ONE, 1'b0);
		send_sample(TB_TIME_TOP, VAL_ZERO, 1'b1);
		// largest time alone, high impedance
		send_sample(TB_TIME_TOP, VAL_Z, 1'b1);
		stop_samples();
		drain(1'b1);

		// Zero end time and zero clock periods: both fractions saturate.
		write_reg(CFG_END_TIME, 64'd0);
		write_reg(CFG_CLOCK_PERIODS, 64'd0);
		send_sample(40'd0, VAL_ONE, 1'b0);
		send_sample(40'd10, VAL_ZERO, 1'b0);
		send_sample(40'd20, VAL_X, 1'b1);
		stop_samples();
		drain(1'b1);

		// Random phases, two per idle pattern, each with its own register setting.
		for (int p = 0; p < 6; p++) begin
			case (p / 2)
				0: begin
					tx_idle_pct = 31;
					rx_idle_pct = 65;
				end
				1: begin
					tx_idle_pct = 65;
					rx_idle_pct = 31;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			case (p)
				0: begin
					end_val = 64'(TB_TIME_TOP);
					cpr_val = 64'(CPR_MAX);
				end
				1: begin
					end_val = 64'd1;
					cpr_val = 64'd1;
				end
				2: begin
					end_val = rand_upto(64'hF_FFFF) + 64'd1;
					cpr_val = 64'($urandom_range(1, 64));
				end
				3: begin
					end_val = rand_upto(64'(TB_TIME_TOP) - 64'd1) + 64'd1;
					cpr_val = 64'($urandom_range(1, 32'hFFFF_FFFE)) + 64'd1;
				end
				4: begin
					end_val = 64'd1000;
					cpr_val = 64'd3;
				end
				default: begin
					end_val = rand_upto(64'h3FFF_FFFF) + 64'd1;
					cpr_val = 64'($urandom_range(1, 65536));
				end
			endcase
			write_reg(CFG_END_TIME, end_val);
			write_reg(CFG_CLOCK_PERIODS, cpr_val);
			// long result-side hold while samples keep coming
			if (p == 2)
				long_hold_req = 1'b1;
			if (p == 4) begin
				send_records(85);
				stop_samples();
				// sender pauses until the meter has emptied
				drain(1'b0);
				send_records(85);
			end else begin
				send_records(170);
			end
			stop_samples();
			drain(1'b1);
		end

		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
